FILE: design/sdt_pkg.sv
// ----------------------------------------------------------------------------
// sdt_pkg
// Shared types and constants of the Sobel double-threshold edge classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package sdt_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int COL_W      = 10;
    localparam int ROW_W      = 12;
    localparam int WIDTH_W    = 11;
    localparam int MAG_W      = 11;
    localparam int PIX_W      = 8;
    localparam int GRAD_W     = 11;
    localparam int SQ_W       = 20;
    localparam int RAD_W      = SQ_W + 1;
    localparam int ROOT_W     = RAD_W + 1;
    localparam int ROOT_STEPS = (RAD_W + 1) / 2;
    localparam int STEP_W     = $clog2(ROOT_STEPS + 1);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd3;

    localparam logic [MAG_W-1:0]   LOW_THRESHOLD_RST  = 11'd110;
    localparam logic [MAG_W-1:0]   HIGH_THRESHOLD_RST = 11'd170;
    localparam logic [WIDTH_W-1:0] IMAGE_WIDTH_RST    = 11'd1024;
    localparam logic [ROW_W-1:0]   IMAGE_HEIGHT_RST   = 12'd480;

    localparam logic [WIDTH_W-1:0] MIN_WIDTH   = 11'd3;
    localparam logic [WIDTH_W-1:0] MAX_WIDTH_V = 11'(MAX_WIDTH);
    localparam logic [ROW_W-1:0]   MIN_HEIGHT  = 12'd3;

    localparam int NUM_SLOTS = 4;
    localparam logic [1:0] SLOT_INNER  = 2'd0;
    localparam logic [1:0] SLOT_RIGHT  = 2'd1;
    localparam logic [1:0] SLOT_BOTTOM = 2'd2;
    localparam logic [1:0] SLOT_CORNER = 2'd3;

    localparam logic [1:0] CLASS_NONE   = 2'd0;
    localparam logic [1:0] CLASS_WEAK   = 2'd1;
    localparam logic [1:0] CLASS_STRONG = 2'd2;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_READ   = 6'b000010,
        S_GRAD   = 6'b000100,
        S_SQUARE = 6'b001000,
        S_LOAD   = 6'b010000,
        S_ROOT   = 6'b100000
    } state_t;

    typedef struct packed {
        logic       accept;
        logic       read;
        logic       grad;
        logic       square;
        logic       root_load;
        logic       root_step;
        logic       out_load;
        logic [1:0] out_sel;
    } cmd_t;

    typedef struct packed {
        logic [NUM_SLOTS-1:0] flags;
        logic                 root_last;
        logic                 out_free;
    } sts_t;

endpackage

`default_nettype wire

FILE: design/sdt_isqrt.sv
// ----------------------------------------------------------------------------
// sdt_isqrt
// Iterative integer square root, two radicand bits per cycle while step is high.
// ----------------------------------------------------------------------------
`default_nettype none

module sdt_isqrt (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        load,
    input  wire logic                        step,
    input  wire logic [sdt_pkg::RAD_W-1:0]   radicand,
    output logic      [sdt_pkg::MAG_W-1:0]   root,
    output logic                             last
);

    logic [sdt_pkg::ROOT_W-1:0] rem_reg, rem_next;
    logic [sdt_pkg::ROOT_W-1:0] res_reg, res_next;
    logic [sdt_pkg::ROOT_W-1:0] bit_reg, bit_next;
    logic [sdt_pkg::STEP_W-1:0] cnt_reg, cnt_next;
    logic [sdt_pkg::ROOT_W-1:0] trial;

    assign trial = res_reg + bit_reg;

    always_comb
    begin
        rem_next = rem_reg;
        res_next = res_reg;
        bit_next = bit_reg;
        cnt_next = cnt_reg;
        if (load)
        begin
            rem_next = {1'b0, radicand};
            res_next = '0;
            bit_next = sdt_pkg::ROOT_W'(1) << (2 * (sdt_pkg::ROOT_STEPS - 1));
            cnt_next = '0;
        end
        else if (step)
        begin
            if (rem_reg >= trial)
            begin
                rem_next = rem_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    assign root = res_reg[sdt_pkg::MAG_W-1:0];
    assign last = (cnt_reg == sdt_pkg::STEP_W'(sdt_pkg::ROOT_STEPS - 1));

endmodule

`default_nettype wire

FILE: design/sdt_dp.sv
// ----------------------------------------------------------------------------
// sdt_dp
// Datapath: configuration, position counters, line stores, window taps,
// Sobel gradients, squares, square root and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sdt_dp (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire sdt_pkg::cmd_t                   cmd,
    output sdt_pkg::sts_t                        sts,
    input  wire logic                            cfg_write,
    input  wire logic [sdt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [sdt_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic [sdt_pkg::PIX_W-1:0]       pixel,
    output logic                                 result_valid,
    input  wire logic                            result_stall,
    output logic      [sdt_pkg::ROW_W-1:0]       out_row,
    output logic      [sdt_pkg::COL_W-1:0]       out_col,
    output logic      [sdt_pkg::MAG_W-1:0]       magnitude,
    output logic      [1:0]                      edge_class,
    output logic                                 frame_last
);

    logic [sdt_pkg::MAG_W-1:0]   low_thr_reg;
    logic [sdt_pkg::MAG_W-1:0]   high_thr_reg;
    logic [sdt_pkg::WIDTH_W-1:0] width_cfg_reg;
    logic [sdt_pkg::ROW_W-1:0]   height_cfg_reg;

    logic [sdt_pkg::ROW_W-1:0]   row_cnt_reg, row_cnt_next;
    logic [sdt_pkg::COL_W-1:0]   col_cnt_reg, col_cnt_next;

    logic [sdt_pkg::WIDTH_W-1:0] w_eff, w_m1;
    logic [sdt_pkg::ROW_W-1:0]   h_eff, h_m1;
    logic [sdt_pkg::ROW_W-1:0]   r_cur;
    logic [sdt_pkg::COL_W-1:0]   c_cur;
    logic                        last_col, last_row;
    logic [sdt_pkg::NUM_SLOTS-1:0] flags_next;

    logic [sdt_pkg::ROW_W-1:0]     r_reg;
    logic [sdt_pkg::COL_W-1:0]     c_reg;
    logic [sdt_pkg::PIX_W-1:0]     pixel_reg;
    logic                          inner_reg;
    logic [sdt_pkg::NUM_SLOTS-1:0] flags_reg;

    logic [sdt_pkg::PIX_W-1:0] upper_mem  [sdt_pkg::MAX_WIDTH];
    logic [sdt_pkg::PIX_W-1:0] middle_mem [sdt_pkg::MAX_WIDTH];
    logic [sdt_pkg::PIX_W-1:0] top_reg, mid_reg;
    logic [sdt_pkg::PIX_W-1:0] taps_reg [6];

    logic [sdt_pkg::COL_W-1:0]          right_sum, left_sum, lower_sum, upper_sum;
    logic signed [sdt_pkg::GRAD_W-1:0]  gx, gy;
    logic signed [sdt_pkg::GRAD_W-1:0]  gx_reg, gy_reg;
    logic signed [2*sdt_pkg::GRAD_W-1:0] gx_sq, gy_sq;
    logic [sdt_pkg::SQ_W-1:0]           sqx_reg, sqy_reg;
    logic [sdt_pkg::RAD_W-1:0]          radicand;
    logic [sdt_pkg::MAG_W-1:0]          root;
    logic                               root_last;

    logic                        result_valid_reg;
    logic [sdt_pkg::ROW_W-1:0]   out_row_reg;
    logic [sdt_pkg::COL_W-1:0]   out_col_reg;
    logic [sdt_pkg::MAG_W-1:0]   magnitude_reg;
    logic [1:0]                  edge_class_reg;
    logic                        frame_last_reg;
    logic [sdt_pkg::ROW_W-1:0]   sel_row;
    logic [sdt_pkg::COL_W-1:0]   sel_col;
    logic [sdt_pkg::MAG_W-1:0]   sel_mag;
    logic [1:0]                  sel_class;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_thr_reg    <= sdt_pkg::LOW_THRESHOLD_RST;
            high_thr_reg   <= sdt_pkg::HIGH_THRESHOLD_RST;
            width_cfg_reg  <= sdt_pkg::IMAGE_WIDTH_RST;
            height_cfg_reg <= sdt_pkg::IMAGE_HEIGHT_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                sdt_pkg::REG_LOW_THRESHOLD:  low_thr_reg    <= cfg_data[sdt_pkg::MAG_W-1:0];
                sdt_pkg::REG_HIGH_THRESHOLD: high_thr_reg   <= cfg_data[sdt_pkg::MAG_W-1:0];
                sdt_pkg::REG_IMAGE_WIDTH:    width_cfg_reg  <= cfg_data[sdt_pkg::WIDTH_W-1:0];
                sdt_pkg::REG_IMAGE_HEIGHT:   height_cfg_reg <= cfg_data;
                default:                     low_thr_reg    <= low_thr_reg;
            endcase
        end
    end

    // clamp frame size, normalize position
    always_comb
    begin
        if (width_cfg_reg < sdt_pkg::MIN_WIDTH)
            w_eff = sdt_pkg::MIN_WIDTH;
        else if (width_cfg_reg > sdt_pkg::MAX_WIDTH_V)
            w_eff = sdt_pkg::MAX_WIDTH_V;
        else
            w_eff = width_cfg_reg;
        h_eff = (height_cfg_reg < sdt_pkg::MIN_HEIGHT) ? sdt_pkg::MIN_HEIGHT : height_cfg_reg;
        w_m1  = w_eff - 1'b1;
        h_m1  = h_eff - 1'b1;

        if (row_cnt_reg >= h_eff)
        begin
            r_cur = '0;
            c_cur = '0;
        end
        else
        begin
            r_cur = row_cnt_reg;
            c_cur = ({1'b0, col_cnt_reg} >= w_eff) ? w_m1[sdt_pkg::COL_W-1:0] : col_cnt_reg;
        end

        last_col = ({1'b0, c_cur} == w_m1);
        last_row = (r_cur == h_m1);

        flags_next[sdt_pkg::SLOT_INNER]  = (r_cur != '0) && (c_cur != '0);
        flags_next[sdt_pkg::SLOT_RIGHT]  = (r_cur != '0) && last_col;
        flags_next[sdt_pkg::SLOT_BOTTOM] = last_row && (c_cur != '0);
        flags_next[sdt_pkg::SLOT_CORNER] = last_row && last_col;

        if (last_col)
        begin
            col_cnt_next = '0;
            row_cnt_next = last_row ? '0 : r_cur + 1'b1;
        end
        else
        begin
            col_cnt_next = c_cur + 1'b1;
            row_cnt_next = r_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cnt_reg <= '0;
            col_cnt_reg <= '0;
        end
        else if (cmd.accept)
        begin
            row_cnt_reg <= row_cnt_next;
            col_cnt_reg <= col_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            r_reg     <= r_cur;
            c_reg     <= c_cur;
            pixel_reg <= pixel;
            inner_reg <= (r_cur >= sdt_pkg::ROW_W'(2)) && (c_cur >= sdt_pkg::COL_W'(2));
            flags_reg <= flags_next;
        end
    end

    // line stores
    always_ff @(posedge clk)
    begin
        if (cmd.read)
        begin
            top_reg <= upper_mem[c_reg[sdt_pkg::ADDR_W-1:0]];
            mid_reg <= middle_mem[c_reg[sdt_pkg::ADDR_W-1:0]];
        end
        if (cmd.grad)
        begin
            upper_mem[c_reg[sdt_pkg::ADDR_W-1:0]]  <= mid_reg;
            middle_mem[c_reg[sdt_pkg::ADDR_W-1:0]] <= pixel_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                taps_reg[i] <= '0;
        end
        else if (cmd.grad)
        begin
            taps_reg[0] <= taps_reg[3];
            taps_reg[1] <= taps_reg[4];
            taps_reg[2] <= taps_reg[5];
            taps_reg[3] <= top_reg;
            taps_reg[4] <= mid_reg;
            taps_reg[5] <= pixel_reg;
        end
    end

    // Sobel kernels
    always_comb
    begin
        right_sum = sdt_pkg::COL_W'(top_reg) + {1'b0, mid_reg, 1'b0}
                  + sdt_pkg::COL_W'(pixel_reg);
        left_sum  = sdt_pkg::COL_W'(taps_reg[0]) + {1'b0, taps_reg[1], 1'b0}
                  + sdt_pkg::COL_W'(taps_reg[2]);
        lower_sum = sdt_pkg::COL_W'(taps_reg[2]) + {1'b0, taps_reg[5], 1'b0}
                  + sdt_pkg::COL_W'(pixel_reg);
        upper_sum = sdt_pkg::COL_W'(taps_reg[0]) + {1'b0, taps_reg[3], 1'b0}
                  + sdt_pkg::COL_W'(top_reg);
        gx = $signed({1'b0, right_sum}) - $signed({1'b0, left_sum});
        gy = $signed({1'b0, lower_sum}) - $signed({1'b0, upper_sum});
    end

    assign gx_sq = gx_reg * gx_reg;
    assign gy_sq = gy_reg * gy_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.grad)
        begin
            gx_reg <= inner_reg ? gx : '0;
            gy_reg <= inner_reg ? gy : '0;
        end
        if (cmd.square)
        begin
            sqx_reg <= gx_sq[sdt_pkg::SQ_W-1:0];
            sqy_reg <= gy_sq[sdt_pkg::SQ_W-1:0];
        end
    end

    assign radicand = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    sdt_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (cmd.root_load),
        .step     (cmd.root_step),
        .radicand (radicand),
        .root     (root),
        .last     (root_last)
    );

    // result select and classing
    always_comb
    begin
        sel_row = r_reg;
        sel_col = c_reg;
        sel_mag = '0;
        unique case (cmd.out_sel)
            sdt_pkg::SLOT_INNER:
            begin
                sel_row = r_reg - 1'b1;
                sel_col = c_reg - 1'b1;
                sel_mag = root;
            end
            sdt_pkg::SLOT_RIGHT:  sel_row = r_reg - 1'b1;
            sdt_pkg::SLOT_BOTTOM: sel_col = c_reg - 1'b1;
            sdt_pkg::SLOT_CORNER: sel_col = c_reg;
            default:              sel_mag = '0;
        endcase
        priority if (sel_mag >= high_thr_reg)
            sel_class = sdt_pkg::CLASS_STRONG;
        else if (sel_mag >= low_thr_reg)
            sel_class = sdt_pkg::CLASS_WEAK;
        else
            sel_class = sdt_pkg::CLASS_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (cmd.out_load)
            result_valid_reg <= 1'b1;
        else if (!result_stall)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_row_reg    <= sel_row;
            out_col_reg    <= sel_col;
            magnitude_reg  <= sel_mag;
            edge_class_reg <= sel_class;
            frame_last_reg <= (cmd.out_sel == sdt_pkg::SLOT_CORNER);
        end
    end

    assign sts.flags     = flags_reg;
    assign sts.root_last = root_last;
    assign sts.out_free  = !result_valid_reg || !result_stall;

    assign result_valid = result_valid_reg;
    assign out_row      = out_row_reg;
    assign out_col      = out_col_reg;
    assign magnitude    = magnitude_reg;
    assign edge_class   = edge_class_reg;
    assign frame_last   = frame_last_reg;

endmodule

`default_nettype wire

FILE: design/sdt_ctrl.sv
// ----------------------------------------------------------------------------
// sdt_ctrl
// Controller: sequences one pixel through read, gradient, square, root and
// result emission.
// ----------------------------------------------------------------------------
`default_nettype none

module sdt_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            pixel_valid,
    output logic                 pixel_stall,
    input  wire sdt_pkg::sts_t   sts,
    output sdt_pkg::cmd_t        cmd
);

    typedef enum logic [1:0] {
        P_RUN  = 2'b01,
        P_EMIT = 2'b10
    } phase_t;

    sdt_pkg::state_t              state_reg, state_next;
    phase_t                       phase_reg, phase_next;
    logic [sdt_pkg::NUM_SLOTS-1:0] pend_reg, pend_next;
    logic [sdt_pkg::NUM_SLOTS-1:0] pend_after;
    logic [1:0]                   first_slot;

    always_comb
    begin
        priority if (pend_reg[sdt_pkg::SLOT_INNER])
            first_slot = sdt_pkg::SLOT_INNER;
        else if (pend_reg[sdt_pkg::SLOT_RIGHT])
            first_slot = sdt_pkg::SLOT_RIGHT;
        else if (pend_reg[sdt_pkg::SLOT_BOTTOM])
            first_slot = sdt_pkg::SLOT_BOTTOM;
        else
            first_slot = sdt_pkg::SLOT_CORNER;
        pend_after = pend_reg & ~(sdt_pkg::NUM_SLOTS'(1) << first_slot);
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        pend_next  = pend_reg;
        cmd        = '0;
        cmd.out_sel = first_slot;
        pixel_stall = 1'b1;

        unique case (state_reg)
            sdt_pkg::S_IDLE:
            begin
                if (phase_reg == P_EMIT)
                begin
                    if (pend_reg == '0)
                        phase_next = P_RUN;
                    else if (sts.out_free)
                    begin
                        cmd.out_load = 1'b1;
                        pend_next    = pend_after;
                        if (pend_after == '0)
                            phase_next = P_RUN;
                    end
                end
                else
                begin
                    pixel_stall = 1'b0;
                    if (pixel_valid)
                    begin
                        cmd.accept = 1'b1;
                        state_next = sdt_pkg::S_READ;
                    end
                end
            end
            sdt_pkg::S_READ:
            begin
                cmd.read   = 1'b1;
                state_next = sdt_pkg::S_GRAD;
            end
            sdt_pkg::S_GRAD:
            begin
                cmd.grad   = 1'b1;
                state_next = sdt_pkg::S_SQUARE;
            end
            sdt_pkg::S_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = sdt_pkg::S_LOAD;
            end
            sdt_pkg::S_LOAD:
            begin
                cmd.root_load = 1'b1;
                state_next    = sdt_pkg::S_ROOT;
            end
            sdt_pkg::S_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (sts.root_last)
                begin
                    state_next = sdt_pkg::S_IDLE;
                    phase_next = P_EMIT;
                    pend_next  = sts.flags;
                end
            end
            default:
            begin
                state_next = sdt_pkg::S_IDLE;
                phase_next = P_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sdt_pkg::S_IDLE;
            phase_reg <= P_RUN;
            pend_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/sobel_double_threshold_top.sv
// ----------------------------------------------------------------------------
// sobel_double_threshold_top
// Streaming Sobel edge classifier with weak and strong thresholds.
//
// Pixels enter in raster order on pixel_valid / pixel_stall with pixel.
// Results leave on result_valid / result_stall with out_row, out_col,
// magnitude, edge_class and frame_last. An item moves when valid is high
// and stall is low.
// After acceptance each pixel passes through a line store read, a gradient
// step, a square step, the load and the steps of the bit-pair square root
// unit and, if it has results, the output load of the first one.
// Its results (none in row 0, up to four on the last pixel) then load one
// per cycle while the receiver keeps up; a pixel without results still
// leaves the emit phase, and a new pixel is accepted only after it ends.
// Configuration writes (cfg_valid / cfg_ready, always ready; cfg_index,
// cfg_data) must occur only while the block is idle; nothing enforces it.
// Reset clears the position counters and window taps and restores the
// default thresholds and frame size; the line stores are not cleared.
// When the receiver stalls, the output register holds its item and the
// block waits before loading the next result.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_double_threshold_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            pixel_valid,
    output logic                                 pixel_stall,
    input  wire logic [sdt_pkg::PIX_W-1:0]       pixel,
    output logic                                 result_valid,
    input  wire logic                            result_stall,
    output logic      [sdt_pkg::ROW_W-1:0]       out_row,
    output logic      [sdt_pkg::COL_W-1:0]       out_col,
    output logic      [sdt_pkg::MAG_W-1:0]       magnitude,
    output logic      [1:0]                      edge_class,
    output logic                                 frame_last,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [sdt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [sdt_pkg::CFG_DATA_W-1:0]  cfg_data
);

    sdt_pkg::cmd_t cmd;
    sdt_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    sdt_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .sts         (sts),
        .cmd         (cmd)
    );

    sdt_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_write    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_row      (out_row),
        .out_col      (out_col),
        .magnitude    (magnitude),
        .edge_class   (edge_class),
        .frame_last   (frame_last)
    );

endmodule

`default_nettype wire
